FILE: rtl/bed_pkg.sv
// Shared types and constants for the button event detector.
// Holds event codes, register indexes and the queued event record; no dependencies.
package bed_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_T_W  = 16;
    localparam int unsigned BTN_W    = 8;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned REG_IX_W = 3;

    // Result queue geometry
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_CLICK   = 3'd2,
        EV_DOUBLE  = 3'd3,
        EV_LONG    = 3'd4
    } t_event_code;

    typedef enum logic [REG_IX_W-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_LONG_PRESS = 3'd1,
        REG_DOUBLE_GAP = 3'd2,
        REG_DOUBLE_EN  = 3'd3,
        REG_BUTTON_ID  = 3'd4
    } t_reg_index;

    localparam logic [CFG_T_W-1:0] RST_DEBOUNCE   = 16'd20;
    localparam logic [CFG_T_W-1:0] RST_LONG_PRESS = 16'd1000;
    localparam logic [CFG_T_W-1:0] RST_DOUBLE_GAP = 16'd300;
    localparam logic               RST_DOUBLE_EN  = 1'b1;
    localparam logic [BTN_W-1:0]   RST_BUTTON_ID  = 8'd0;

    typedef struct packed {
        t_event_code             code;
        logic [BTN_W-1:0]        button;
        logic                    last;
    } t_event;

endpackage

FILE: rtl/button_event_detector.sv
// Top level of the button event detector: APB register file, poll input register,
// event state machine and a small result queue. Depends on bed_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  poll    | in        | i_valid / o_stall  | i_raw_level, i_now
//  event   | out       | o_valid / i_stall  | o_event_code, o_event_button, o_last_event
//  config  | in        | APB (psel,penable) | paddr, pwdata, prdata (pready tied high)
//
// A poll is taken into the input register and evaluated from there, and its zero, one
// or two events enter a four-entry result queue; the queue is registered, so the first
// event is on the outputs from the cycle after the poll is evaluated.
// One poll per cycle is sustained while the event side drains; the event port moves
// one event per cycle while i_stall is low, so polls that make two events can back up through the queue.
// Reset (synchronous, active low) returns the state machine to idle, clears its
// timestamps and flags, empties the queue and loads the register defaults.
// o_stall rises only when the held poll cannot enter the queue with room for two.
module button_event_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Poll channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_raw_level,
    input  logic [bed_pkg::TIME_W-1:0]    i_now,
    // Event channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_event_code,
    output logic [bed_pkg::BTN_W-1:0]     o_event_button,
    output logic                          o_last_event,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bed_pkg::ADDR_W-1:0]    paddr,
    input  logic [bed_pkg::DATA_W-1:0]    pwdata,
    output logic [bed_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import bed_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_DEB_PRESS = 2'd1,
        ST_PRESSED   = 2'd2,
        ST_DEB_REL   = 2'd3
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_T_W-1:0] r_debounce_time;
    logic [CFG_T_W-1:0] r_long_press_time;
    logic [CFG_T_W-1:0] r_double_gap_time;
    logic               r_double_enable;
    logic [BTN_W-1:0]   r_button_id;

    logic               cfg_wr;
    t_reg_index         cfg_ix;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_ix = t_reg_index'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= RST_DEBOUNCE;
            r_long_press_time <= RST_LONG_PRESS;
            r_double_gap_time <= RST_DOUBLE_GAP;
            r_double_enable   <= RST_DOUBLE_EN;
            r_button_id       <= RST_BUTTON_ID;
        end else if (cfg_wr) begin
            case (cfg_ix)
                REG_DEBOUNCE:   r_debounce_time   <= pwdata[CFG_T_W-1:0];
                REG_LONG_PRESS: r_long_press_time <= pwdata[CFG_T_W-1:0];
                REG_DOUBLE_GAP: r_double_gap_time <= pwdata[CFG_T_W-1:0];
                REG_DOUBLE_EN:  r_double_enable   <= pwdata[0];
                REG_BUTTON_ID:  r_button_id       <= pwdata[BTN_W-1:0];
                default: ;      // addresses past the register list are ignored
            endcase
        end
    end

    // Read back is a plain mux over the register file.
    always_comb begin
        prdata = '0;
        case (cfg_ix)
            REG_DEBOUNCE:   prdata = {{(DATA_W-CFG_T_W){1'b0}}, r_debounce_time};
            REG_LONG_PRESS: prdata = {{(DATA_W-CFG_T_W){1'b0}}, r_long_press_time};
            REG_DOUBLE_GAP: prdata = {{(DATA_W-CFG_T_W){1'b0}}, r_double_gap_time};
            REG_DOUBLE_EN:  prdata = {{(DATA_W-1){1'b0}}, r_double_enable};
            REG_BUTTON_ID:  prdata = {{(DATA_W-BTN_W){1'b0}}, r_button_id};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Poll input register
    // ------------------------------------------------------------------
    logic                r_in_valid;
    logic                r_raw;
    logic [TIME_W-1:0]   r_now;
    logic                advance;   // held poll is evaluated and its events queued

    logic [Q_CW-1:0]     r_cnt;

    // Always leave room for the worst case of two events per poll.
    assign advance = r_in_valid && (r_cnt <= Q_CW'(Q_DEPTH - 2));
    assign o_stall = r_in_valid && !advance;

    // ------------------------------------------------------------------
    // Event state machine
    // ------------------------------------------------------------------
    t_state             r_state,        n_state;
    logic [TIME_W-1:0]  r_edge_time,    n_edge_time;
    logic [TIME_W-1:0]  r_press_time,   n_press_time;
    logic [TIME_W-1:0]  r_click_time,   n_click_time;
    logic               r_click_pending, n_click_pending;
    logic               r_long_fired,   n_long_fired;
    logic               r_double_press, n_double_press;

    // Elapsed times wrap modulo 2^32.
    logic [TIME_W-1:0]  since_edge;
    logic [TIME_W-1:0]  since_press;
    logic [TIME_W-1:0]  since_click;
    logic               deb_done;
    logic               long_done;
    logic               gap_done;

    assign since_edge  = r_now - r_edge_time;
    assign since_press = r_now - r_press_time;
    assign since_click = r_now - r_click_time;
    assign deb_done    = since_edge  >= {{(TIME_W-CFG_T_W){1'b0}}, r_debounce_time};
    assign long_done   = since_press >= {{(TIME_W-CFG_T_W){1'b0}}, r_long_press_time};
    assign gap_done    = since_click >= {{(TIME_W-CFG_T_W){1'b0}}, r_double_gap_time};

    t_event_code        ev0_code;
    t_event_code        ev1_code;
    logic [1:0]         ev_num;

    always_comb begin
        n_state         = r_state;
        n_edge_time     = r_edge_time;
        n_press_time    = r_press_time;
        n_click_time    = r_click_time;
        n_click_pending = r_click_pending;
        n_long_fired    = r_long_fired;
        n_double_press  = r_double_press;
        ev0_code        = EV_PRESS;
        ev1_code        = EV_PRESS;
        ev_num          = 2'd0;

        case (r_state)
            ST_IDLE: begin
                // A new press wins over a click timeout in the same poll.
                if (r_raw) begin
                    n_edge_time = r_now;
                    n_state     = ST_DEB_PRESS;
                end else if (r_click_pending && gap_done) begin
                    n_click_pending = 1'b0;
                    ev0_code        = EV_CLICK;
                    ev_num          = 2'd1;
                end
            end
            ST_DEB_PRESS: begin
                if (!r_raw) begin
                    n_state = ST_IDLE;
                end else if (deb_done) begin
                    ev0_code     = EV_PRESS;
                    ev_num       = 2'd1;
                    n_press_time = r_now;
                    n_long_fired = 1'b0;
                    if (r_click_pending && r_double_enable && !gap_done) begin
                        n_click_pending = 1'b0;
                        n_double_press  = 1'b1;
                        ev1_code        = EV_DOUBLE;
                        ev_num          = 2'd2;
                    end else begin
                        n_double_press = 1'b0;
                    end
                    n_state = ST_PRESSED;
                end
            end
            ST_PRESSED: begin
                if (!r_raw) begin
                    n_edge_time = r_now;
                    n_state     = ST_DEB_REL;
                end else if (!r_long_fired && !r_double_press && long_done) begin
                    n_long_fired = 1'b1;
                    ev0_code     = EV_LONG;
                    ev_num       = 2'd1;
                end
            end
            default: begin
                if (r_raw) begin
                    n_state = ST_PRESSED;
                end else if (deb_done) begin
                    ev0_code = EV_RELEASE;
                    ev_num   = 2'd1;
                    // Arm a delayed click, or report it now when doubles are off.
                    if (!r_long_fired && !r_double_press) begin
                        if (r_double_enable) begin
                            n_click_pending = 1'b1;
                            n_click_time    = r_now;
                        end else begin
                            ev1_code = EV_CLICK;
                            ev_num   = 2'd2;
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    t_event             r_queue [Q_DEPTH];
    logic [Q_AW-1:0]    r_wptr;
    logic [Q_AW-1:0]    r_rptr;
    logic [Q_CW-1:0]    push_num;
    logic               pop;
    t_event             ev0;
    t_event             ev1;
    t_event             head;

    assign push_num = advance ? Q_CW'(ev_num) : '0;
    assign pop      = o_valid && !i_stall;

    assign ev0 = '{code: ev0_code, button: r_button_id, last: (ev_num == 2'd1)};
    assign ev1 = '{code: ev1_code, button: r_button_id, last: 1'b1};

    assign head           = r_queue[r_rptr];
    assign o_valid        = (r_cnt != '0);
    assign o_event_code   = head.code;
    assign o_event_button = head.button;
    assign o_last_event   = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_state         <= ST_IDLE;
            r_edge_time     <= '0;
            r_press_time    <= '0;
            r_click_time    <= '0;
            r_click_pending <= 1'b0;
            r_long_fired    <= 1'b0;
            r_double_press  <= 1'b0;
            r_wptr          <= '0;
            r_rptr          <= '0;
            r_cnt           <= '0;
        end else begin
            // Load a new poll whenever the input register is free or draining.
            if (!o_stall) begin
                r_in_valid <= i_valid;
                if (i_valid) begin
                    r_raw <= i_raw_level;
                    r_now <= i_now;
                end
            end

            if (advance) begin
                r_state         <= n_state;
                r_edge_time     <= n_edge_time;
                r_press_time    <= n_press_time;
                r_click_time    <= n_click_time;
                r_click_pending <= n_click_pending;
                r_long_fired    <= n_long_fired;
                r_double_press  <= n_double_press;
                if (ev_num != 2'd0) begin
                    r_queue[r_wptr] <= ev0;
                end
                if (ev_num == 2'd2) begin
                    r_queue[r_wptr + Q_AW'(1)] <= ev1;
                end
            end

            r_wptr <= r_wptr + push_num[Q_AW-1:0];
            if (pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            r_cnt <= r_cnt + push_num - Q_CW'(pop);
        end
    end

endmodule
